FILE: hw/rtl/bclru_pkg.sv
// Package for the LRU block cache tag table: codes and sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bclru_pkg;
    localparam int ENTRIES_DEF = 16;
    localparam int BLK_W = 32;
    localparam int TICK_W = 32;
    localparam int REF_W = 8;
    // packed slot record: status, refcount, block, last use
    localparam int REC_W = 2 + REF_W + BLK_W + TICK_W;

    typedef enum logic [1:0] {
        K_ACQUIRE = 2'd0, K_RELEASE = 2'd1, K_DIRTY = 2'd2, K_SYNC = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0, ST_PREFETCH = 2'd1, ST_CLEAN = 2'd2, ST_DIRTY = 2'd3
    } ent_st_t;

    typedef enum logic [2:0] {
        R_HIT = 3'd0, R_FILL = 3'd1, R_WB_FILL = 3'd2, R_NO_ROOM = 3'd3,
        R_DONE = 3'd4, R_SYNC_WB = 3'd5, R_REF_ERR = 3'd6, R_UNDERFLOW = 3'd7
    } res_t;

    typedef struct packed {
        ent_st_t          st;
        logic [REF_W-1:0] refc;
        logic [BLK_W-1:0] blk;
        logic [TICK_W-1:0] lu;
    } rec_t;
endpackage
`default_nettype wire

FILE: hw/rtl/bclru_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bclru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/block_cache_lru_clean_first_top.sv
// Top level of the LRU block cache tag table (clean victim first).
// Depends on bclru_pkg and bclru_ram.
//
//  channel  | handshake          | payload
//  command  | start / busy       | kind block_number prefetch slot_index now_tick drop_level
//  result   | strobe (no stall)  | status slot_out read_block write_block last
//
// Slot records live in one RAM; valid bits (reset clears them) stand for the
// reset state, so no clearing pass is needed. Release and mark-dirty read the
// slot, then modify/write it. Acquire reads one slot a cycle and stops early
// on a hit. Sync makes up to two passes over the slots (write-back, then drop),
// then a closing state.
// Results come out one per cycle at most; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module block_cache_lru_clean_first_top
    import bclru_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output      logic              busy,
    input  wire logic [1:0]        kind,
    input  wire logic [BLK_W-1:0]  block_number,
    input  wire logic              prefetch,
    input  wire logic [3:0]        slot_index,
    input  wire logic [TICK_W-1:0] now_tick,
    input  wire logic [1:0]        drop_level,
    output      logic              strobe,
    output      logic [2:0]        status,
    output      logic [3:0]        slot_out,
    output      logic [BLK_W-1:0]  read_block,
    output      logic [BLK_W-1:0]  write_block,
    output      logic              last
);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = AW + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SLOT  = 7'b0000010, // release / mark dirty: data arriving
        S_SCAN  = 7'b0000100, // acquire lookup
        S_FIN   = 7'b0001000, // acquire decision and write
        S_WB    = 7'b0010000, // sync write-back pass
        S_DROP  = 7'b0100000, // sync drop pass
        S_END   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // command registers
    kind_t             kind_reg;
    logic [BLK_W-1:0]  bn_reg;
    logic              pre_reg;
    logic [AW-1:0]     slot_reg;
    logic [TICK_W-1:0] now_reg;
    logic [1:0]        lvl_reg;

    logic [CW-1:0] cnt_reg, cnt_next;     // read address counter
    logic [CW-1:0] dcnt_reg, dcnt_next;   // slot whose data is at rdata
    logic          dv_reg, dv_next;       // rdata holds a scanned slot

    logic [ENTRIES-1:0] valid_reg, valid_next;

    // scan results
    logic          hit_v_reg, hit_v_next, emp_v_reg, emp_v_next;
    logic          cln_v_reg, cln_v_next, drt_v_reg, drt_v_next;
    logic [AW-1:0] hit_reg, hit_next, emp_reg, emp_next;
    logic [AW-1:0] cln_reg, cln_next, drt_reg, drt_next;
    rec_t          hitr_reg, hitr_next;
    logic [TICK_W-1:0] clu_reg, clu_next, dlu_reg, dlu_next;
    logic [BLK_W-1:0]  dblk_reg, dblk_next;

    // RAM
    logic          we;
    logic [AW-1:0] waddr, raddr;
    rec_t          wdata, rdata, rec;

    bclru_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [AW-1:0] daddr;
    assign daddr = dcnt_reg[AW-1:0];

    // empty record substituted for never-written slots
    always_comb
    begin
        rec = rdata;
        if (!valid_reg[daddr])
        begin
            rec.st = ST_EMPTY;
            rec.refc = '0;
        end
    end

    // outputs
    logic          strobe_next, last_next;
    res_t          status_next;
    logic [3:0]    slot_out_next;
    logic [BLK_W-1:0] rd_next, wr_next;
    res_t          status_reg;

    assign busy = (state_reg != S_IDLE);
    assign status = status_reg;

    logic in_range;
    assign in_range = ({1'b0, slot_index} < 5'(ENTRIES));

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        dcnt_next = cnt_reg;
        dv_next = 1'b0;
        valid_next = valid_reg;
        hit_v_next = hit_v_reg; hit_next = hit_reg; hitr_next = hitr_reg;
        emp_v_next = emp_v_reg; emp_next = emp_reg;
        cln_v_next = cln_v_reg; cln_next = cln_reg; clu_next = clu_reg;
        drt_v_next = drt_v_reg; drt_next = drt_reg; dlu_next = dlu_reg;
        dblk_next = dblk_reg;
        we = 1'b0;
        waddr = daddr;
        wdata = rec;
        raddr = cnt_reg[AW-1:0];
        strobe_next = 1'b0;
        last_next = 1'b1;
        status_next = R_DONE;
        slot_out_next = '0;
        rd_next = '0;
        wr_next = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                raddr = slot_index[AW-1:0];
                // valid bit of the addressed slot must follow its data
                dcnt_next = {1'b0, slot_index[AW-1:0]};
                if (start)
                begin
                    cnt_next = '0;
                    hit_v_next = 1'b0; emp_v_next = 1'b0;
                    cln_v_next = 1'b0; drt_v_next = 1'b0;
                    unique case (kind_t'(kind))
                        K_ACQUIRE: state_next = S_SCAN;
                        K_SYNC:    state_next = S_WB;
                        default:
                        begin
                            if (in_range)
                            begin
                                state_next = S_SLOT;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                                slot_out_next = slot_index;
                                state_next = S_END;
                            end
                        end
                    endcase
                end
            end
            S_SLOT:
            begin
                waddr = slot_reg;
                strobe_next = 1'b1;
                slot_out_next = 4'(slot_reg);
                if (kind_reg == K_RELEASE)
                begin
                    if (rec.refc == '0)
                    begin
                        status_next = R_UNDERFLOW;
                    end
                    else
                    begin
                        wdata.refc = rec.refc - 1'b1;
                        we = 1'b1;
                    end
                end
                else if (rec.st != ST_EMPTY)
                begin
                    wdata.st = ST_DIRTY;
                    we = 1'b1;
                end
                state_next = S_END;
            end
            S_SCAN:
            begin
                // issue next read, examine previous data
                if (cnt_reg < CW'(ENTRIES))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    dv_next = 1'b1;
                end
                if (dv_reg)
                begin
                    if (rec.st == ST_EMPTY)
                    begin
                        if (!emp_v_reg)
                        begin
                            emp_v_next = 1'b1; emp_next = daddr;
                        end
                    end
                    else if (rec.blk == bn_reg)
                    begin
                        hit_v_next = 1'b1; hit_next = daddr; hitr_next = rec;
                    end
                    else if (rec.refc == '0 && rec.blk > BLK_W'(1))
                    begin
                        if (rec.st != ST_DIRTY)
                        begin
                            if (!cln_v_reg || rec.lu < clu_reg)
                            begin
                                cln_v_next = 1'b1; cln_next = daddr; clu_next = rec.lu;
                            end
                        end
                        else if (!drt_v_reg || rec.lu < dlu_reg)
                        begin
                            drt_v_next = 1'b1; drt_next = daddr; dlu_next = rec.lu;
                            dblk_next = rec.blk;
                        end
                    end
                end
                if (hit_v_next || (!dv_reg && cnt_reg == CW'(ENTRIES)))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                strobe_next = 1'b1;
                wdata.lu = now_reg;
                wdata.blk = bn_reg;
                if (hit_v_reg)
                begin
                    we = 1'b1;
                    waddr = hit_reg;
                    wdata.refc = hitr_reg.refc;
                    if (!pre_reg && hitr_reg.refc != '1)
                    begin
                        wdata.refc = hitr_reg.refc + 1'b1;
                    end
                    wdata.st = (hitr_reg.st == ST_PREFETCH) ? ST_CLEAN : hitr_reg.st;
                    status_next = R_HIT;
                    slot_out_next = 4'(hit_reg);
                end
                else if (emp_v_reg || cln_v_reg || (drt_v_reg && !pre_reg))
                begin
                    we = 1'b1;
                    if (emp_v_reg)
                    begin
                        waddr = emp_reg; status_next = R_FILL;
                    end
                    else if (cln_v_reg)
                    begin
                        waddr = cln_reg; status_next = R_FILL;
                    end
                    else
                    begin
                        waddr = drt_reg; status_next = R_WB_FILL; wr_next = dblk_reg;
                    end
                    wdata.st = pre_reg ? ST_PREFETCH : ST_CLEAN;
                    wdata.refc = pre_reg ? '0 : REF_W'(1);
                    slot_out_next = 4'(waddr);
                    rd_next = bn_reg;
                end
                else
                begin
                    status_next = R_NO_ROOM;
                end
                if (we)
                begin
                    valid_next[waddr] = 1'b1;
                end
                state_next = S_END;
            end
            S_WB:
            begin
                if (cnt_reg < CW'(ENTRIES))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    dv_next = 1'b1;
                end
                if (dv_reg && rec.st == ST_DIRTY)
                begin
                    we = 1'b1;
                    wdata.st = (rec.refc == '0) ? ST_EMPTY : ST_CLEAN;
                    strobe_next = 1'b1;
                    last_next = 1'b0;
                    status_next = R_SYNC_WB;
                    slot_out_next = 4'(daddr);
                    wr_next = rec.blk;
                end
                if (!dv_reg && cnt_reg == CW'(ENTRIES))
                begin
                    cnt_next = '0;
                    if (lvl_reg == 2'd0)
                    begin
                        strobe_next = 1'b1;
                        state_next = S_END;
                    end
                    else
                    begin
                        state_next = S_DROP;
                    end
                end
            end
            S_DROP:
            begin
                // a read-after-write hazard cannot arise: each slot is read once
                if (cnt_reg < CW'(ENTRIES))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    dv_next = 1'b1;
                end
                if (dv_reg)
                begin
                    if (rec.refc != '0 && lvl_reg[1] && rec.blk >= BLK_W'(2))
                    begin
                        strobe_next = 1'b1;
                        status_next = R_REF_ERR;
                        slot_out_next = 4'(daddr);
                        state_next = S_END;
                    end
                    else if (rec.refc == '0)
                    begin
                        we = 1'b1;
                        wdata.st = ST_EMPTY;
                    end
                end
                if (state_next != S_END && !dv_reg && cnt_reg == CW'(ENTRIES))
                begin
                    strobe_next = 1'b1;
                    state_next = S_END;
                end
            end
            S_END:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            strobe    <= 1'b0;
            dv_reg    <= 1'b0;
            cnt_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            strobe    <= strobe_next;
            dv_reg    <= dv_next;
            cnt_reg   <= cnt_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            kind_reg <= kind_t'(kind);
            bn_reg   <= block_number;
            pre_reg  <= prefetch;
            slot_reg <= slot_index[AW-1:0];
            now_reg  <= now_tick;
            lvl_reg  <= drop_level;
        end
        hit_v_reg <= hit_v_next; hit_reg <= hit_next; hitr_reg <= hitr_next;
        emp_v_reg <= emp_v_next; emp_reg <= emp_next;
        cln_v_reg <= cln_v_next; cln_reg <= cln_next; clu_reg <= clu_next;
        drt_v_reg <= drt_v_next; drt_reg <= drt_next; dlu_reg <= dlu_next;
        dblk_reg  <= dblk_next;
        status_reg  <= status_next;
        slot_out    <= slot_out_next;
        read_block  <= rd_next;
        write_block <= wr_next;
        last        <= last_next;
    end
endmodule
`default_nettype wire

FILE: verif/block_cache_lru_clean_first_checker.sv
// Checker for the LRU block cache tag table: watches the command and result
// channels, predicts results per transaction and compares. Depends on bclru_pkg.
`timescale 1ns / 1ps
module block_cache_lru_clean_first_checker
    import bclru_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        kind,
    input  logic [BLK_W-1:0]  block_number,
    input  logic              prefetch,
    input  logic [3:0]        slot_index,
    input  logic [TICK_W-1:0] now_tick,
    input  logic [1:0]        drop_level,
    input  logic              strobe,
    input  logic [2:0]        status,
    input  logic [3:0]        slot_out,
    input  logic [BLK_W-1:0]  read_block,
    input  logic [BLK_W-1:0]  write_block,
    input  logic              last,
    output int                errors,
    output int                pending
);
    localparam int NSLOT = ENTRIES_DEF;
    localparam int QDEPTH = 32;

    typedef struct {
        res_t              code;
        logic [3:0]        slot;
        logic [BLK_W-1:0]  rd;
        logic [BLK_W-1:0]  wr;
        logic              fin;
    } cache_res_t;

    ent_st_t           slot_st  [NSLOT];
    logic [BLK_W-1:0]  slot_blk [NSLOT];
    logic [REF_W-1:0]  slot_refs[NSLOT];
    logic [TICK_W-1:0] slot_used[NSLOT];

    // expected results, oldest first
    cache_res_t        want_mem[QDEPTH];
    int                want_wr;
    int                want_rd;
    int                want_cnt;

    function automatic cache_res_t mk(res_t c, int s, logic [BLK_W-1:0] rd,
                                      logic [BLK_W-1:0] wr, logic fin);
        cache_res_t r;
        r.code = c;
        r.slot = s[3:0];
        r.rd   = rd;
        r.wr   = wr;
        r.fin  = fin;
        return r;
    endfunction

    task automatic expect_res(cache_res_t r);
        if (want_cnt >= QDEPTH)
        begin
            $display("%0t: expected-result store overflow", $time);
            errors++;
            return;
        end
        want_mem[want_wr] = r;
        want_wr = (want_wr + 1) % QDEPTH;
        want_cnt++;
    endtask

    task automatic bump_ref(int s);
        if (slot_refs[s] != 8'hFF)
            slot_refs[s] = slot_refs[s] + 1'b1;
    endtask

    task automatic lookup_or_fill(logic [BLK_W-1:0] bn, logic pre, logic [TICK_W-1:0] t);
        int empty_s, clean_s, dirty_s, hit_s, s;
        res_t code;
        logic [BLK_W-1:0] wb;
        empty_s = -1; clean_s = -1; dirty_s = -1; hit_s = -1; wb = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (slot_st[i] == ST_EMPTY)
            begin
                if (empty_s < 0)
                    empty_s = i;
            end
            else if (slot_blk[i] == bn)
            begin
                hit_s = i;
                break;
            end
            else if (slot_refs[i] == 0 && slot_blk[i] > 1)
            begin
                if (slot_st[i] != ST_DIRTY)
                begin
                    if (clean_s < 0 || slot_used[i] < slot_used[clean_s])
                        clean_s = i;
                end
                else if (dirty_s < 0 || slot_used[i] < slot_used[dirty_s])
                begin
                    dirty_s = i;
                end
            end
        end
        if (hit_s >= 0)
        begin
            if (!pre)
                bump_ref(hit_s);
            if (slot_st[hit_s] == ST_PREFETCH)
                slot_st[hit_s] = ST_CLEAN;
            slot_used[hit_s] = t;
            expect_res(mk(R_HIT, hit_s, '0, '0, 1'b1));
            return;
        end
        if (empty_s >= 0)
        begin
            s = empty_s; code = R_FILL;
        end
        else if (clean_s >= 0)
        begin
            s = clean_s; code = R_FILL;
        end
        else if (dirty_s >= 0 && !pre)
        begin
            s = dirty_s; code = R_WB_FILL; wb = slot_blk[dirty_s];
        end
        else
        begin
            expect_res(mk(R_NO_ROOM, 0, '0, '0, 1'b1));
            return;
        end
        slot_blk[s]  = bn;
        slot_st[s]   = pre ? ST_PREFETCH : ST_CLEAN;
        slot_refs[s] = '0;
        if (!pre)
            bump_ref(s);
        slot_used[s] = t;
        expect_res(mk(code, s, bn, wb, 1'b1));
    endtask

    task automatic flush_table(logic [1:0] lvl);
        for (int i = 0; i < NSLOT; i++)
        begin
            if (slot_st[i] == ST_DIRTY)
            begin
                expect_res(mk(R_SYNC_WB, i, '0, slot_blk[i], 1'b0));
                slot_st[i] = (slot_refs[i] == 0) ? ST_EMPTY : ST_CLEAN;
            end
        end
        if (lvl > 0)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                if (slot_refs[i] > 0 && lvl > 1 && slot_blk[i] >= 2)
                begin
                    expect_res(mk(R_REF_ERR, i, '0, '0, 1'b1));
                    return;
                end
                if (slot_refs[i] == 0)
                    slot_st[i] = ST_EMPTY;
            end
        end
        expect_res(mk(R_DONE, 0, '0, '0, 1'b1));
    endtask

    task automatic take_command();
        int s;
        s = slot_index;
        case (kind_t'(kind))
            K_ACQUIRE: lookup_or_fill(block_number, prefetch, now_tick);
            K_SYNC:    flush_table(drop_level);
            K_RELEASE:
            begin
                if (s < NSLOT && slot_refs[s] == 0)
                begin
                    expect_res(mk(R_UNDERFLOW, s, '0, '0, 1'b1));
                end
                else
                begin
                    if (s < NSLOT)
                        slot_refs[s] = slot_refs[s] - 1'b1;
                    expect_res(mk(R_DONE, s, '0, '0, 1'b1));
                end
            end
            default:
            begin
                if (s < NSLOT && slot_st[s] != ST_EMPTY)
                    slot_st[s] = ST_DIRTY;
                expect_res(mk(R_DONE, s, '0, '0, 1'b1));
            end
        endcase
    endtask

    task automatic check_result();
        cache_res_t w;
        if (want_cnt == 0)
        begin
            $display("%0t: unexpected result status=%0d slot=%0d", $time, status, slot_out);
            errors++;
            return;
        end
        w = want_mem[want_rd];
        want_rd = (want_rd + 1) % QDEPTH;
        want_cnt--;
        if (status !== w.code)
        begin
            $display("%0t: status expected %0d actual %0d", $time, w.code, status);
            errors++;
        end
        if (slot_out !== w.slot)
        begin
            $display("%0t: slot_out expected %0d actual %0d", $time, w.slot, slot_out);
            errors++;
        end
        if (read_block !== w.rd)
        begin
            $display("%0t: read_block expected %h actual %h", $time, w.rd, read_block);
            errors++;
        end
        if (write_block !== w.wr)
        begin
            $display("%0t: write_block expected %h actual %h", $time, w.wr, write_block);
            errors++;
        end
        if (last !== w.fin)
        begin
            $display("%0t: last expected %0b actual %0b", $time, w.fin, last);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        want_wr = 0;
        want_rd = 0;
        want_cnt = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                slot_st[i]   = ST_EMPTY;
                slot_blk[i]  = '0;
                slot_refs[i] = '0;
                slot_used[i] = '0;
            end
            want_wr = 0;
            want_rd = 0;
            want_cnt = 0;
        end
        else
        begin
            // results of earlier transactions first, then the new command
            if (strobe)
                check_result();
            if (start && !busy)
                take_command();
        end
        pending = want_cnt;
    end
endmodule

FILE: verif/tb_block_cache_lru_clean_first_top.sv
// Testbench top for block_cache_lru_clean_first_top: directed and random
// commands, idle phases, verdict. Depends on bclru_pkg and the checker module.
`timescale 1ns / 1ps
module tb_block_cache_lru_clean_first_top
    import bclru_pkg::*;
();
    localparam int QUIET_LIMIT = 3000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        kind = K_ACQUIRE;
    logic [BLK_W-1:0]  block_number = '0;
    logic              prefetch = 1'b0;
    logic [3:0]        slot_index = '0;
    logic [TICK_W-1:0] now_tick = '0;
    logic [1:0]        drop_level = '0;
    logic              strobe;
    logic [2:0]        status;
    logic [3:0]        slot_out;
    logic [BLK_W-1:0]  read_block;
    logic [BLK_W-1:0]  write_block;
    logic              last;
    int                errors;
    int                pending;
    int                idle_pct = 0;
    int                quiet = 0;
    logic [TICK_W-1:0] clock_tick = 32'd100;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    block_cache_lru_clean_first_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .block_number(block_number), .prefetch(prefetch), .slot_index(slot_index),
        .now_tick(now_tick), .drop_level(drop_level), .strobe(strobe),
        .status(status), .slot_out(slot_out), .read_block(read_block),
        .write_block(write_block), .last(last)
    );

    block_cache_lru_clean_first_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .block_number(block_number), .prefetch(prefetch), .slot_index(slot_index),
        .now_tick(now_tick), .drop_level(drop_level), .strobe(strobe),
        .status(status), .slot_out(slot_out), .read_block(read_block),
        .write_block(write_block), .last(last), .errors(errors), .pending(pending)
    );

    // watchdog: no transaction on either channel for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL block_cache_lru_clean_first_top");
            $finish;
        end
    end

    // start stays high across back-to-back commands; lowered only when idling
    task automatic issue(kind_t k, logic [BLK_W-1:0] bn, logic pre, logic [3:0] si,
                         logic [TICK_W-1:0] t, logic [1:0] lvl);
        @(negedge clk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        kind = k; block_number = bn; prefetch = pre; slot_index = si;
        now_tick = t; drop_level = lvl; start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic acquire(logic [BLK_W-1:0] bn, logic pre);
        clock_tick = clock_tick + 1;
        issue(K_ACQUIRE, bn, pre, 4'($urandom), clock_tick, 2'($urandom));
    endtask

    task automatic random_command();
        int r;
        logic [BLK_W-1:0] bn;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            case ($urandom_range(0, 9))
                0: bn = $urandom;
                1: bn = $urandom_range(0, 1);
                default: bn = $urandom_range(2, 27);
            endcase
            if ($urandom_range(0, 9) == 0)
                clock_tick = $urandom;
            else
                clock_tick = clock_tick + $urandom_range(0, 3);
            issue(K_ACQUIRE, bn, $urandom_range(0, 3) == 0, 4'($urandom), clock_tick,
                  2'($urandom));
        end
        else if (r < 72)
            issue(K_RELEASE, $urandom, 1'($urandom), 4'($urandom), $urandom, 2'($urandom));
        else if (r < 87)
            issue(K_DIRTY, $urandom, 1'($urandom), 4'($urandom), $urandom, 2'($urandom));
        else
            issue(K_SYNC, $urandom, 1'($urandom), 4'($urandom), $urandom,
                  2'($urandom_range(0, 3)));
    endtask

    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed: fills, reserved blocks, prefetch, underflow, dirty, syncs
        issue(K_RELEASE, '0, 1'b0, 4'd15, '0, '0);
        issue(K_DIRTY, '0, 1'b0, 4'd3, '0, '0);
        acquire(32'd0, 1'b0);
        acquire(32'd1, 1'b0);
        acquire(32'hFFFF_FFFF, 1'b0);
        acquire(32'd7, 1'b1);
        acquire(32'd7, 1'b1);
        acquire(32'd7, 1'b0);
        issue(K_DIRTY, '0, 1'b0, 4'd2, '0, '0);
        issue(K_RELEASE, '0, 1'b0, 4'd2, '0, '0);
        issue(K_RELEASE, '0, 1'b0, 4'd2, '0, '0);
        issue(K_SYNC, '0, 1'b0, '0, '0, 2'd0);
        for (int b = 0; b < 14; b++)
            acquire(32'd100 + b, b[0]);
        acquire(32'd500, 1'b1);
        issue(K_DIRTY, '0, 1'b0, 4'd3, '0, '0);
        issue(K_RELEASE, '0, 1'b0, 4'd3, '0, '0);
        acquire(32'd501, 1'b1);
        acquire(32'd502, 1'b0);
        issue(K_SYNC, '0, 1'b0, '0, '0, 2'd2);
        issue(K_SYNC, '0, 1'b0, '0, '0, 2'd1);
        issue(K_SYNC, '0, 1'b0, '0, '0, 2'd3);
        settle();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 65 : (ph == 3) ? 21 : 0;
            for (int n = 0; n < 19; n++)
                random_command();
        end
        settle();

        if (errors == 0)
            $display("PASS block_cache_lru_clean_first_top");
        else
            $display("FAIL block_cache_lru_clean_first_top");
        $finish;
    end
endmodule
